// File: design/cfsr_pkg.sv
package cfsr_pkg;

	// One link byte, as stored and as sent.
	typedef logic [7:0] byte_t;

	// Number of checksum bytes that open every frame.
	localparam int unsigned SUM_BYTES = 4;

	// Request codes on req_type.
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_SLOT = 2'd1;
	localparam logic [1:0] REQ_RESP = 2'd2;

	// Result codes on out_kind.
	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_DELIVERED = 2'd1;
	localparam logic [1:0] KIND_RETRY     = 2'd2;

endpackage

// File: design/checksum_frame_sender_with_retry_unit.sv
// Additive-checksum frame sender with stop-and-wait retry.
// Requests arrive as command beats: req_type, data_byte and last_byte are taken
// at a rising edge where start is high and busy is low. A load beat stores one
// packet byte and adds it to a 32-bit wrapping sum while the buffer has room;
// last_byte closes the load. Each transmit-slot beat returns one frame byte: the
// four sum bytes, low byte first, then the stored packet. After the final byte a
// response beat either matches the ack code (frame delivered, loading reopens)
// or restarts the frame. The ack code is written through cfg_we / cfg_wdata and
// resets to 89. Results pass through the stage-one and output registers and
// appear on out_kind, out_byte and frame_last for one cycle, flagged by
// out_strobe; the receiver cannot stall. A load beat leaves busy low. A slot or
// response beat raises busy while its result is in the stage-one register, so no
// new beat is taken until it moves on. Wrong-phase beats and request code 3
// are accepted and give no result. Reset clears the sum, length and phase; the
// buffer needs no clearing, since only written entries are ever read back.
module checksum_frame_sender_with_retry_unit
	import cfsr_pkg::*;
#(
	parameter int unsigned MAX_PACKET_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic       out_strobe,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       frame_last
);

	localparam int unsigned AW = $clog2(MAX_PACKET_BYTES);
	localparam int unsigned LW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + SUM_BYTES + 1);

	localparam logic [1:0] PH_LOADING = 2'd0;
	localparam logic [1:0] PH_SENDING = 2'd1;
	localparam logic [1:0] PH_WAITING = 2'd2;

	logic [1:0]    phase_q;
	logic [LW-1:0] len_q;
	logic [31:0]   sum_q;
	logic [PW-1:0] pos_q;
	byte_t         ack_code_q;

	logic          valid_s1;
	logic [1:0]    kind_s1;
	byte_t         sum_byte_s1;
	logic          from_mem_s1;
	logic          last_s1;

	logic          accept;
	logic          is_loading;
	logic          room;
	logic          mem_we;
	logic          mem_re;
	logic [PW-1:0] total;
	logic [PW-1:0] pos_next;
	logic          final_byte;
	logic          from_mem;
	logic [PW-1:0] mem_idx;
	byte_t         sum_byte;
	byte_t         rdata;

	assign busy       = valid_s1;
	assign accept     = start && !busy;
	assign is_loading = (phase_q != PH_SENDING) && (phase_q != PH_WAITING);
	assign room       = len_q < LW'(MAX_PACKET_BYTES);
	assign mem_we     = accept && (req_type == REQ_LOAD) && is_loading && room;
	assign mem_re     = accept && (req_type == REQ_SLOT) && (phase_q == PH_SENDING);

	// Frame position bookkeeping for a slot beat.
	assign total      = PW'(SUM_BYTES) + PW'(len_q);
	assign pos_next   = pos_q + PW'(1);
	assign final_byte = pos_next >= total;
	assign from_mem   = pos_q >= PW'(SUM_BYTES);
	assign mem_idx    = pos_q - PW'(SUM_BYTES);

	// Sum byte picked by the low position bits.
	always_comb begin
		case (pos_q[1:0])
			2'd0:    sum_byte = sum_q[7:0];
			2'd1:    sum_byte = sum_q[15:8];
			2'd2:    sum_byte = sum_q[23:16];
			default: sum_byte = sum_q[31:24];
		endcase
	end

	cfsr_store #(
		.DEPTH(MAX_PACKET_BYTES),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(len_q[AW-1:0]),
		.wdata(data_byte),
		.re   (mem_re),
		.raddr(mem_idx[AW-1:0]),
		.rdata(rdata)
	);

	// Ack code register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q <= 8'd89;
		end else if (cfg_we) begin
			ack_code_q <= cfg_wdata;
		end
	end

	// Phase machine with length, sum and position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOADING;
			len_q   <= '0;
			sum_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			unique case (req_type)
				REQ_LOAD: begin
					if (is_loading) begin
						if (room) begin
							len_q <= len_q + LW'(1);
							sum_q <= sum_q + 32'(data_byte);
						end
						if (last_byte) begin
							phase_q <= PH_SENDING;
							pos_q   <= '0;
						end
					end
				end
				REQ_SLOT: begin
					if (phase_q == PH_SENDING) begin
						pos_q <= pos_next;
						if (final_byte) begin
							phase_q <= PH_WAITING;
						end
					end
				end
				REQ_RESP: begin
					if (phase_q == PH_WAITING) begin
						pos_q   <= '0;
						if (data_byte == ack_code_q) begin
							phase_q <= PH_LOADING;
							len_q   <= '0;
							sum_q   <= '0;
						end else begin
							phase_q <= PH_SENDING;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// First stage: result under way while the buffer read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept
				&& (((req_type == REQ_SLOT) && (phase_q == PH_SENDING))
				|| ((req_type == REQ_RESP) && (phase_q == PH_WAITING)));
		end
	end

	always_ff @(posedge clk) begin
		if (req_type == REQ_SLOT) begin
			kind_s1     <= KIND_BYTE;
			sum_byte_s1 <= sum_byte;
			from_mem_s1 <= from_mem;
			last_s1     <= final_byte;
		end else begin
			kind_s1     <= (data_byte == ack_code_q) ? KIND_DELIVERED : KIND_RETRY;
			sum_byte_s1 <= '0;
			from_mem_s1 <= 1'b0;
			last_s1     <= 1'b0;
		end
	end

	// Output register: one-cycle result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_strobe <= 1'b0;
		end else begin
			out_strobe <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_kind   <= kind_s1;
		out_byte   <= from_mem_s1 ? rdata : sum_byte_s1;
		frame_last <= last_s1;
	end

endmodule

// File: design/cfsr_store.sv
// Packet buffer: one write port and one read port, read data registered.
module cfsr_store
	import cfsr_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  byte_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output byte_t         rdata
);

	byte_t mem [DEPTH];

	// Write side.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read side, read data registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/checksum_frame_sender_with_retry_unit_test.sv
`timescale 1ns / 100ps

module checksum_frame_sender_with_retry_unit_test;
	import cfsr_pkg::*;

	localparam int unsigned PACKET_DEPTH = 256;
	localparam int BEAT_TARGET = 1000;
	localparam int DRAIN_CYCLES = 6;
	localparam int CYCLE_LIMIT = 300000;
	// Request code 3 has no meaning and must be ignored.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef enum logic [1:0] {PH_LOADING, PH_SENDING, PH_AWAITING} link_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		byte_t      value;
		logic       last;
	} link_result_t;

	typedef struct packed {
		bit         is_cfg;
		logic [1:0] req;
		byte_t      data;
		logic       last;
		bit         calm;
	} link_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] req_type = REQ_LOAD;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       out_strobe;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       frame_last;

	// Commands waiting to be driven, and link results still to arrive.
	link_cmd_t    pending_cmds[$];
	link_result_t link_results_due[$];

	// Shadow copy of the sender state.
	byte_t       shadow_store[PACKET_DEPTH];
	logic [8:0]  shadow_fill = '0;
	logic [31:0] shadow_sum = '0;
	logic [8:0]  shadow_pos = '0;
	link_phase_t shadow_phase = PH_LOADING;
	byte_t       shadow_ack = 8'd89;

	// Stimulus planning state.
	byte_t planned_ack = 8'd89;
	bit    calm_run = 1'b0;
	int    beats_planned = 0;

	logic beat_taken = 1'b0;
	int   gap_left = 0;
	int   quiet_cycles = 0;
	int   cycle_count = 0;
	int   mismatches = 0;

	checksum_frame_sender_with_retry_unit #(
		.MAX_PACKET_BYTES(PACKET_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_strobe(out_strobe),
		.out_kind(out_kind),
		.out_byte(out_byte),
		.frame_last(frame_last)
	);

	always #2 clk = ~clk;

	// Advance the shadow state by one accepted beat and record the result it causes.
	function automatic void predict_link_output(logic [1:0] req, byte_t data, logic last);
		byte_t      sent;
		logic       closing;
		logic [8:0] rd_idx;
		case (req)
			REQ_LOAD: begin
				if (shadow_phase == PH_LOADING) begin
					// A full store drops the byte, but its last flag still counts.
					if (shadow_fill < 9'(PACKET_DEPTH)) begin
						shadow_store[shadow_fill[7:0]] = data;
						shadow_fill = shadow_fill + 9'd1;
						shadow_sum = shadow_sum + 32'(data);
					end
					if (last) begin
						shadow_phase = PH_SENDING;
						shadow_pos = '0;
					end
				end
			end
			REQ_SLOT: begin
				if (shadow_phase == PH_SENDING) begin
					if (shadow_pos < 9'(SUM_BYTES)) begin
						sent = byte_t'(shadow_sum >> (8 * shadow_pos[1:0]));
					end else begin
						rd_idx = shadow_pos - 9'(SUM_BYTES);
						sent = shadow_store[rd_idx[7:0]];
					end
					closing = (shadow_pos + 9'd1 >= 9'(SUM_BYTES) + shadow_fill);
					shadow_pos = shadow_pos + 9'd1;
					if (closing)
						shadow_phase = PH_AWAITING;
					link_results_due.push_back('{KIND_BYTE, sent, closing});
				end
			end
			REQ_RESP: begin
				if (shadow_phase == PH_AWAITING) begin
					if (data == shadow_ack) begin
						shadow_fill = '0;
						shadow_sum = '0;
						shadow_pos = '0;
						shadow_phase = PH_LOADING;
						link_results_due.push_back('{KIND_DELIVERED, 8'h00, 1'b0});
					end else begin
						shadow_pos = '0;
						shadow_phase = PH_SENDING;
						link_results_due.push_back('{KIND_RETRY, 8'h00, 1'b0});
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_beat(logic [1:0] req, byte_t data, logic last, bit counts);
		pending_cmds.push_back('{1'b0, req, data, last, calm_run});
		if (counts)
			beats_planned++;
	endfunction

	function automatic void queue_ack_write(byte_t code);
		pending_cmds.push_back('{1'b1, REQ_LOAD, code, 1'b0, calm_run});
		planned_ack = code;
	endfunction

	// A beat that the given phase must ignore.
	function automatic void queue_stray(link_phase_t ph);
		logic [1:0] req;
		case ($urandom_range(0, 2))
			0: req = (ph == PH_LOADING) ? REQ_SLOT : REQ_LOAD;
			1: req = (ph == PH_AWAITING) ? REQ_SLOT : REQ_RESP;
			default: req = REQ_UNUSED;
		endcase
		queue_beat(req, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
	endfunction

	// One full exchange: load, send, and answer until the frame is delivered.
	function automatic void queue_frame(int len);
		int    link_bytes;
		bit    again;
		byte_t reply;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				queue_stray(PH_LOADING);
			queue_beat(REQ_LOAD, byte_t'($urandom_range(0, 255)), i == len - 1, 1'b1);
		end
		link_bytes = SUM_BYTES + ((len < PACKET_DEPTH) ? len : PACKET_DEPTH);
		do begin
			for (int s = 0; s < link_bytes; s++) begin
				if ($urandom_range(0, 7) == 0)
					queue_stray(PH_SENDING);
				queue_beat(REQ_SLOT, byte_t'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'b1);
			end
			if ($urandom_range(0, 7) == 0)
				queue_stray(PH_AWAITING);
			again = ($urandom_range(0, 3) == 0);
			reply = planned_ack;
			while (again && reply == planned_ack)
				reply = byte_t'($urandom_range(0, 255));
			queue_beat(REQ_RESP, reply, 1'($urandom_range(0, 1)), 1'b1);
		end while (again);
	endfunction

	// Driver: launch beats and ack code writes at the falling edge.
	always @(negedge clk) begin
		logic start_next;
		logic we_next;
		start_next = start && !beat_taken;
		we_next = 1'b0;
		if (arst_n && !start_next) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending_cmds.size() != 0) begin
				if (pending_cmds[0].is_cfg) begin
					// The ack code changes only once the sender has gone quiet.
					if (link_results_due.size() == 0 && quiet_cycles >= DRAIN_CYCLES) begin
						cfg_wdata <= pending_cmds[0].data;
						we_next = 1'b1;
						void'(pending_cmds.pop_front());
					end
				end else begin
					req_type <= pending_cmds[0].req;
					data_byte <= pending_cmds[0].data;
					last_byte <= pending_cmds[0].last;
					start_next = 1'b1;
					if (!pending_cmds[0].calm && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 19);
					void'(pending_cmds.pop_front());
				end
			end
		end
		start <= start_next;
		cfg_we <= we_next;
	end

	// Monitor: check results, then track accepted beats and ack code writes.
	always @(posedge clk) begin
		link_result_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_strobe) begin
				if (link_results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d byte %02h last %0b",
						$time, out_kind, out_byte, frame_last);
					mismatches++;
				end else begin
					want = link_results_due.pop_front();
					if (out_kind !== want.kind) begin
						$display("%0t: out_kind expected %0d actual %0d", $time, want.kind, out_kind);
						mismatches++;
					end
					if (out_byte !== want.value) begin
						$display("%0t: out_byte expected %02h actual %02h", $time, want.value, out_byte);
						mismatches++;
					end
					if (frame_last !== want.last) begin
						$display("%0t: frame_last expected %0b actual %0b", $time, want.last,
							frame_last);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				shadow_ack = cfg_wdata;
			beat_taken <= start && !busy;
			if (start && !busy) begin
				predict_link_output(req_type, data_byte, last_byte);
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("checksum_frame_sender_with_retry_unit_test failed");
		$finish;
	end

	initial begin
		int frame_no;
		int len;

		// Stray beats while loading, including a response equal to the ack code.
		queue_beat(REQ_SLOT, 8'h00, 1'b1, 1'b0);
		queue_beat(REQ_RESP, planned_ack, 1'b0, 1'b0);
		queue_beat(REQ_UNUSED, 8'hFF, 1'b1, 1'b0);
		// Short packet with extreme byte values.
		queue_beat(REQ_LOAD, 8'h00, 1'b0, 1'b1);
		queue_beat(REQ_LOAD, 8'hFF, 1'b0, 1'b1);
		queue_beat(REQ_LOAD, 8'h80, 1'b1, 1'b1);
		// Stray load and response while sending.
		queue_beat(REQ_LOAD, 8'h55, 1'b1, 1'b0);
		queue_beat(REQ_RESP, planned_ack, 1'b1, 1'b0);
		repeat (7) queue_beat(REQ_SLOT, 8'h00, 1'b0, 1'b1);
		// Stray slot and load while awaiting the reply, then a refusal.
		queue_beat(REQ_SLOT, 8'hFF, 1'b1, 1'b0);
		queue_beat(REQ_LOAD, 8'hAA, 1'b1, 1'b0);
		queue_beat(REQ_RESP, 8'hFF, 1'b0, 1'b1);
		repeat (7) queue_beat(REQ_SLOT, 8'hFF, 1'b1, 1'b1);
		queue_beat(REQ_RESP, planned_ack, 1'b1, 1'b1);

		// Random frames, mostly short, with a full store and an overflowing one.
		frame_no = 0;
		while (beats_planned < BEAT_TARGET) begin
			if (frame_no == 1)
				queue_ack_write(8'h00);
			else if (frame_no == 4)
				queue_ack_write(8'hFF);
			else if (frame_no % 3 == 1)
				queue_ack_write(byte_t'($urandom_range(0, 255)));
			calm_run = (frame_no % 6 == 3);
			if (frame_no == 8)
				len = PACKET_DEPTH;
			else if (frame_no == 14)
				len = $urandom_range(PACKET_DEPTH + 1, PACKET_DEPTH + 8);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(17, 64);
			else
				len = $urandom_range(1, 16);
			queue_frame(len);
			frame_no++;
		end
		// The closing stretch runs without gaps.
		calm_run = 1'b1;
		repeat (4) queue_frame($urandom_range(1, 16));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (link_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("checksum_frame_sender_with_retry_unit_test passed");
		else
			$display("checksum_frame_sender_with_retry_unit_test failed");
		$finish;
	end

endmodule
